// File: rtl/nmea_sentence_framer_filter_defines.svh
// ---------------------------------------------------------------------------
// NMEA sentence framer assertion macros
// Shared property forms for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_FRAMER_FILTER_DEFINES_SVH
`define NMEA_SENTENCE_FRAMER_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NSFF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NSFF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/nsff_pkg.sv
// ---------------------------------------------------------------------------
// NMEA sentence framer package
// Character codes, sentence kind codes, verdict type and hex decoding.
// ---------------------------------------------------------------------------
package nsff_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [7:0] CH_R = 8'h52;
    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_A = 8'h41;

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_RMC   = 2'd1;
    localparam logic [1:0] KIND_GGA   = 2'd2;

    typedef struct packed {
        logic       accepted;
        logic       checksum_ok;
        logic [1:0] sentence_kind;
        logic [7:0] computed_checksum;
        logic [6:0] line_length;
    } verdict_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.is_hex = 1'b0;
        d.value  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d.is_hex = 1'b1;
            d.value  = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d.is_hex = 1'b1;
            d.value  = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d.is_hex = 1'b1;
            d.value  = 4'(c - 8'h37);
        end
        return d;
    endfunction

endpackage

// File: rtl/nsff_line_state.sv
// ---------------------------------------------------------------------------
// NMEA line state
// Running per-line registers: length, checksum, hex field and kind match,
// plus the verdict they give for the line seen so far.
// ---------------------------------------------------------------------------
module nsff_line_state
    import nsff_pkg::*;
#(
    parameter int LINE_BUFFER_SIZE = 128
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    output verdict_t   verdict
);

    localparam int CW = $clog2(LINE_BUFFER_SIZE);
    localparam logic [CW-1:0] LIMIT = CW'(LINE_BUFFER_SIZE - 1);

    logic [CW-1:0] char_count_reg, char_count_next;
    logic          dollar_reg, dollar_next;
    logic [7:0]    xor_reg, xor_next;
    logic          star_reg, star_next;
    logic [1:0]    hex_cnt_reg, hex_cnt_next;
    logic          hex_done_reg, hex_done_next;
    logic [7:0]    given_reg, given_next;
    logic          rmc_reg, rmc_next;
    logic          gga_reg, gga_next;

    hex_digit_t    hd;
    logic          long_enough;
    logic [1:0]    kind;
    logic          ok;

    always_comb
    begin
        char_count_next = char_count_reg;
        dollar_next     = dollar_reg;
        xor_next        = xor_reg;
        star_next       = star_reg;
        hex_cnt_next    = hex_cnt_reg;
        hex_done_next   = hex_done_reg;
        given_next      = given_reg;
        rmc_next        = rmc_reg;
        gga_next        = gga_reg;
        hd              = hex_decode(data_byte);

        if (step && data_byte != CH_CR)
        begin
            if (data_byte == CH_LF || char_count_reg >= LIMIT)
            begin
                // end of line or overflow: drop the whole line state
                char_count_next = '0;
                dollar_next     = 1'b0;
                xor_next        = 8'd0;
                star_next       = 1'b0;
                hex_cnt_next    = 2'd0;
                hex_done_next   = 1'b0;
                given_next      = 8'd0;
                rmc_next        = 1'b1;
                gga_next        = 1'b1;
            end
            else
            begin
                if (char_count_reg == '0)
                begin
                    dollar_next = (data_byte == CH_DOLLAR);
                end
                else if (star_reg)
                begin
                    if (!hex_done_reg)
                    begin
                        if (!hd.is_hex)
                        begin
                            hex_done_next = 1'b1;
                        end
                        else
                        begin
                            given_next   = {given_reg[3:0], hd.value};
                            hex_cnt_next = hex_cnt_reg + 2'd1;
                            if (hex_cnt_reg != 2'd0)
                            begin
                                hex_done_next = 1'b1;
                            end
                        end
                    end
                end
                else if (data_byte == CH_STAR)
                begin
                    star_next = 1'b1;
                end
                else
                begin
                    xor_next = xor_reg ^ data_byte;
                end

                case (char_count_reg)
                    CW'(3):
                    begin
                        if (data_byte != CH_R) rmc_next = 1'b0;
                        if (data_byte != CH_G) gga_next = 1'b0;
                    end
                    CW'(4):
                    begin
                        if (data_byte != CH_M) rmc_next = 1'b0;
                        if (data_byte != CH_G) gga_next = 1'b0;
                    end
                    CW'(5):
                    begin
                        if (data_byte != CH_C) rmc_next = 1'b0;
                        if (data_byte != CH_A) gga_next = 1'b0;
                    end
                    default:
                    begin
                        rmc_next = rmc_next;
                    end
                endcase

                char_count_next = char_count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg <= '0;
            dollar_reg     <= 1'b0;
            xor_reg        <= 8'd0;
            star_reg       <= 1'b0;
            hex_cnt_reg    <= 2'd0;
            hex_done_reg   <= 1'b0;
            given_reg      <= 8'd0;
            rmc_reg        <= 1'b1;
            gga_reg        <= 1'b1;
        end
        else
        begin
            char_count_reg <= char_count_next;
            dollar_reg     <= dollar_next;
            xor_reg        <= xor_next;
            star_reg       <= star_next;
            hex_cnt_reg    <= hex_cnt_next;
            hex_done_reg   <= hex_done_next;
            given_reg      <= given_next;
            rmc_reg        <= rmc_next;
            gga_reg        <= gga_next;
        end
    end

    always_comb
    begin
        long_enough = (char_count_reg >= CW'(6));
        if (long_enough && rmc_reg)
        begin
            kind = KIND_RMC;
        end
        else if (long_enough && gga_reg)
        begin
            kind = KIND_GGA;
        end
        else
        begin
            kind = KIND_OTHER;
        end
        ok = dollar_reg && star_reg && (hex_cnt_reg != 2'd0) && (given_reg == xor_reg);

        verdict.accepted          = ok && (kind != KIND_OTHER);
        verdict.checksum_ok       = ok;
        verdict.sentence_kind     = kind;
        verdict.computed_checksum = xor_reg;
        verdict.line_length       = 7'(char_count_reg);
    end

endmodule

// File: rtl/nmea_sentence_framer_filter.sv
// ---------------------------------------------------------------------------
// NMEA sentence framer and checksum filter
// Frames a receiver byte stream on LF and gives one verdict per line.
// ---------------------------------------------------------------------------
//  channel | signals                                   | moves
//  --------+-------------------------------------------+------------------------
//  in      | in_valid, in_stall, data_byte             | one received byte
//  out     | out_valid, out_stall, accepted,           | one verdict per LF
//          | checksum_ok, sentence_kind,               |
//          | computed_checksum, line_length            |
//
//  One byte per cycle while not stalled: the byte sits in an input register,
//  the line state updates from it, and an LF loads the result register.
//  Reset clears the line state and both valid registers.
//  A stalled result holds only an LF behind it; other bytes keep flowing.
// ---------------------------------------------------------------------------
module nmea_sentence_framer_filter
    import nsff_pkg::*;
#(
    parameter int LINE_BUFFER_SIZE = 128
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       accepted,
    output logic       checksum_ok,
    output logic [1:0] sentence_kind,
    output logic [7:0] computed_checksum,
    output logic [6:0] line_length
);

    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg, s1_byte_next;
    logic       out_valid_reg, out_valid_next;
    verdict_t   result_reg, result_next;

    verdict_t   verdict;
    logic       s1_is_lf;
    logic       out_free;
    logic       s1_advance;
    logic       step;
    logic       load_result;

    assign s1_is_lf    = (s1_byte_reg == CH_LF);
    assign out_free    = !out_valid_reg || !out_stall;
    assign s1_advance  = !s1_is_lf || out_free;
    assign step        = s1_valid_reg && s1_advance;
    assign load_result = step && s1_is_lf;
    assign in_stall    = s1_valid_reg && !s1_advance;

    nsff_line_state #(
        .LINE_BUFFER_SIZE(LINE_BUFFER_SIZE)
    ) u_line_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (s1_byte_reg),
        .verdict   (verdict)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_byte_next  = s1_byte_reg;
        if (in_valid && !in_stall)
        begin
            s1_valid_next = 1'b1;
            s1_byte_next  = data_byte;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        if (load_result)
        begin
            out_valid_next = 1'b1;
            result_next    = verdict;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_byte_reg <= s1_byte_next;
        result_reg  <= result_next;
    end

    assign out_valid         = out_valid_reg;
    assign accepted          = result_reg.accepted;
    assign checksum_ok       = result_reg.checksum_ok;
    assign sentence_kind     = result_reg.sentence_kind;
    assign computed_checksum = result_reg.computed_checksum;
    assign line_length       = result_reg.line_length;

endmodule

// File: rtl/nsff_checker.sv
// ---------------------------------------------------------------------------
// NMEA sentence framer port checker
// Watches the top level's ports and flags inconsistent verdicts.
// ---------------------------------------------------------------------------
`include "nmea_sentence_framer_filter_defines.svh"

module nsff_checker
    import nsff_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       accepted,
    input  logic       checksum_ok,
    input  logic [1:0] sentence_kind,
    input  logic [7:0] computed_checksum,
    input  logic [6:0] line_length
);

    logic        out_held;
    logic        empty_out;
    logic        short_out;
    logic        rmc_or_gga;
    logic [18:0] out_word;

    assign out_held   = out_valid && out_stall;
    assign empty_out  = out_valid && (line_length == 7'd0);
    assign short_out  = out_valid && (line_length < 7'd6);
    assign rmc_or_gga = (sentence_kind == KIND_RMC) || (sentence_kind == KIND_GGA);
    assign out_word   = {accepted, checksum_ok, sentence_kind, computed_checksum, line_length};

    `NSFF_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_word), "held item changed")
    `NSFF_ASSERT_NOW(a_accept_ok, out_valid && accepted, checksum_ok && rmc_or_gga, "bad accept")
    `NSFF_ASSERT_NOW(a_empty_line, empty_out, !checksum_ok && ~|computed_checksum, "empty line")
    `NSFF_ASSERT_NOW(a_short, short_out, sentence_kind == KIND_OTHER, "short kind")
    `NSFF_ASSERT_NOW(a_in_stall, in_valid && in_stall, out_held, "stall with no cause")

endmodule

bind nmea_sentence_framer_filter nsff_checker u_nsff_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .accepted          (accepted),
    .checksum_ok       (checksum_ok),
    .sentence_kind     (sentence_kind),
    .computed_checksum (computed_checksum),
    .line_length       (line_length)
);

// File: tb/nsff_verdict_checker.sv
// ---------------------------------------------------------------------------
// NMEA sentence verdict checker
// Tracks the line state from every accepted byte, queues the verdict that
// each LF should produce, and compares each accepted verdict field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nsff_verdict_checker
    import nsff_pkg::*;
#(
    parameter int LINE_BUFFER_SIZE = 128
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       accepted,
    input  logic       checksum_ok,
    input  logic [1:0] sentence_kind,
    input  logic [7:0] computed_checksum,
    input  logic [6:0] line_length,
    output int         mismatches,
    output int         verdicts_owed
);

    // line state
    logic [6:0] chars_held;
    logic       lead_dollar;
    logic [7:0] xor_sum;
    logic       star_found;
    logic [1:0] hex_seen;
    logic       hex_closed;
    logic [7:0] sum_given;
    logic       maybe_rmc;
    logic       maybe_gga;

    verdict_t   verdicts_due[$];

    task automatic note_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic clear_line();
        chars_held  = '0;
        lead_dollar = 1'b0;
        xor_sum     = '0;
        star_found  = 1'b0;
        hex_seen    = '0;
        hex_closed  = 1'b0;
        sum_given   = '0;
        maybe_rmc   = 1'b1;
        maybe_gga   = 1'b1;
    endtask

    task automatic track_byte(input logic [7:0] b);
        verdict_t   v;
        logic [1:0] kind;
        logic       ok;
        logic       is_digit;
        logic [3:0] nibble;
        logic [7:0] rmc_ch;
        logic [7:0] gga_ch;
        if (b == CH_LF)
        begin
            kind = KIND_OTHER;
            if (chars_held >= 7'd6 && maybe_rmc)
                kind = KIND_RMC;
            else if (chars_held >= 7'd6 && maybe_gga)
                kind = KIND_GGA;
            ok = lead_dollar && star_found && hex_seen != 2'd0 && sum_given == xor_sum;
            v.accepted          = ok && kind != KIND_OTHER;
            v.checksum_ok       = ok;
            v.sentence_kind     = kind;
            v.computed_checksum = xor_sum;
            v.line_length       = chars_held;
            verdicts_due.push_back(v);
            clear_line();
        end
        else if (b != CH_CR)
        begin
            if (int'(chars_held) >= LINE_BUFFER_SIZE - 1)
            begin
                // overflow: drop the byte and restart the line
                clear_line();
            end
            else
            begin
                if (chars_held == 7'd0)
                    lead_dollar = (b == CH_DOLLAR);
                else if (star_found)
                begin
                    if (!hex_closed)
                    begin
                        is_digit = 1'b1;
                        nibble   = '0;
                        if (b >= 8'h30 && b <= 8'h39)
                            nibble = b[3:0];
                        else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
                            nibble = b[3:0] + 4'd9;
                        else
                            is_digit = 1'b0;
                        if (!is_digit)
                            hex_closed = 1'b1;
                        else
                        begin
                            sum_given = {sum_given[3:0], nibble};
                            hex_seen  = hex_seen + 2'd1;
                            if (hex_seen == 2'd2)
                                hex_closed = 1'b1;
                        end
                    end
                end
                else if (b == CH_STAR)
                    star_found = 1'b1;
                else
                    xor_sum ^= b;

                if (chars_held >= 7'd3 && chars_held <= 7'd5)
                begin
                    case (chars_held)
                        7'd3:    begin rmc_ch = CH_R; gga_ch = CH_G; end
                        7'd4:    begin rmc_ch = CH_M; gga_ch = CH_G; end
                        default: begin rmc_ch = CH_C; gga_ch = CH_A; end
                    endcase
                    if (b != rmc_ch)
                        maybe_rmc = 1'b0;
                    if (b != gga_ch)
                        maybe_gga = 1'b0;
                end
                chars_held = chars_held + 7'd1;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t v;
        if (!rst_n)
        begin
            clear_line();
            verdicts_due  = {};
            mismatches    = 0;
            verdicts_owed = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdicts_due.size() == 0)
                    note_mismatch("verdict with none expected");
                else
                begin
                    v = verdicts_due.pop_front();
                    if (accepted !== v.accepted)
                        note_mismatch($sformatf("accepted %b, expected %b",
                                                accepted, v.accepted));
                    if (checksum_ok !== v.checksum_ok)
                        note_mismatch($sformatf("checksum_ok %b, expected %b",
                                                checksum_ok, v.checksum_ok));
                    if (sentence_kind !== v.sentence_kind)
                        note_mismatch($sformatf("sentence_kind %0d, expected %0d",
                                                sentence_kind, v.sentence_kind));
                    if (computed_checksum !== v.computed_checksum)
                        note_mismatch($sformatf("computed_checksum %h, expected %h",
                                                computed_checksum, v.computed_checksum));
                    if (line_length !== v.line_length)
                        note_mismatch($sformatf("line_length %0d, expected %0d",
                                                line_length, v.line_length));
                end
            end
            if (in_valid && !in_stall)
                track_byte(data_byte);
            verdicts_owed = verdicts_due.size();
        end
    end

endmodule

// File: tb/tb_top.sv
// ---------------------------------------------------------------------------
// NMEA sentence framer testbench
// Drives short directed lines, then random sentences, noise and overlong
// lines with random gaps and output stalls; the checker predicts each verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import nsff_pkg::*;

    localparam int LINE_BUF     = 128;
    localparam int BYTE_TARGET  = 1275;
    localparam int LINE_TARGET  = 40;
    localparam int IDLE_LIMIT   = 2000;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic [7:0] data_byte  = '0;
    logic       out_stall  = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic       accepted;
    logic       checksum_ok;
    logic [1:0] sentence_kind;
    logic [7:0] computed_checksum;
    logic [6:0] line_length;

    int         mismatches;
    int         verdicts_owed;
    int         idle_cycles = 0;
    int         bytes_sent  = 0;
    int         lines_sent  = 0;
    bit         burst_mode  = 1'b0;
    logic [7:0] line_buf[$];

    always #4 clk = ~clk;

    nmea_sentence_framer_filter #(.LINE_BUFFER_SIZE(LINE_BUF)) dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .data_byte         (data_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .accepted          (accepted),
        .checksum_ok       (checksum_ok),
        .sentence_kind     (sentence_kind),
        .computed_checksum (computed_checksum),
        .line_length       (line_length)
    );

    nsff_verdict_checker #(.LINE_BUFFER_SIZE(LINE_BUF)) u_checker
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .data_byte         (data_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .accepted          (accepted),
        .checksum_ok       (checksum_ok),
        .sentence_kind     (sentence_kind),
        .computed_checksum (computed_checksum),
        .line_length       (line_length),
        .mismatches        (mismatches),
        .verdicts_owed     (verdicts_owed)
    );

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
            return 8'h30 + 8'(n);
        return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    // XOR of the line after its first byte, up to the star; CR is never stored
    function automatic logic [7:0] line_sum();
        logic [7:0] s;
        s = '0;
        for (int k = 1; k < line_buf.size(); k++)
        begin
            if (line_buf[k] == CH_STAR)
                break;
            if (line_buf[k] != CH_CR)
                s ^= line_buf[k];
        end
        return s;
    endfunction

    // enter and leave at a falling edge; valid stays high after the item
    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_line();
        foreach (line_buf[k])
            push_byte(line_buf[k]);
        lines_sent++;
    endtask

    // receiver: hold some verdicts with out_stall once they show
    initial
    begin
        int hold;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            hold = (burst_mode || $urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 14);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                @(posedge clk);
                while (!out_valid)
                    @(posedge clk);
                repeat (hold) @(negedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!(out_valid && !out_stall))
                @(posedge clk);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        logic [7:0] sum;
        logic [7:0] c;
        logic [7:0] tag [3];
        int         kind_sel;
        int         form;
        int         n;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty line
        line_buf = {CH_LF};
        send_line();
        // "$GPRMC*hh" with lowercase digits and CR before LF
        line_buf = {CH_DOLLAR, CH_G, 8'h50, CH_R, CH_M, CH_C, CH_STAR};
        sum = line_sum();
        line_buf.push_back(hex_char(sum[7:4], 1'b1));
        line_buf.push_back(hex_char(sum[3:0], 1'b1));
        line_buf.push_back(CH_CR);
        line_buf.push_back(CH_LF);
        send_line();
        // short line with zero and all-ones bytes
        line_buf = {8'h00, 8'hFF, CH_STAR, CH_LF};
        send_line();
        // "$GNGGA*" with no digits after the star
        line_buf = {CH_DOLLAR, CH_G, 8'h4E, CH_G, CH_G, CH_A, CH_STAR, CH_LF};
        send_line();

        while (bytes_sent < BYTE_TARGET || lines_sent < LINE_TARGET)
        begin
            burst_mode = ($urandom_range(0, 3) == 0);
            if (lines_sent % 10 == 0)
            begin
                // hold the sender until every verdict is out
                in_valid <= 1'b0;
                @(negedge clk);
                while (verdicts_owed != 0)
                    @(negedge clk);
            end

            if (lines_sent % 12 == 5)
            begin
                // long line: past the buffer limit, overflow restarts the line mid-stream
                line_buf = {CH_DOLLAR};
                n = $urandom_range(120, 135);
                repeat (n)
                begin
                    do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
                    line_buf.push_back(c);
                end
                line_buf.push_back(CH_LF);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                line_buf = {};
                if ($urandom_range(0, 1) == 1)
                    line_buf.push_back(CH_DOLLAR);
                n = $urandom_range(0, 12);
                repeat (n)
                    line_buf.push_back(8'($urandom_range(0, 255)));
                line_buf.push_back(CH_LF);
            end
            else
            begin
                line_buf = {CH_DOLLAR};
                repeat (2)
                    line_buf.push_back(8'h41 + 8'($urandom_range(0, 25)));
                kind_sel = $urandom_range(0, 3);
                if ($urandom_range(0, 1) == 1)
                    tag = '{CH_R, CH_M, CH_C};
                else
                    tag = '{CH_G, CH_G, CH_A};
                if (kind_sel == 2)
                begin
                    foreach (tag[k])
                        tag[k] = 8'h41 + 8'($urandom_range(0, 25));
                end
                else if (kind_sel == 3)
                    tag[2'($urandom_range(0, 2))] = 8'h41 + 8'($urandom_range(0, 25));
                foreach (tag[k])
                    line_buf.push_back(tag[k]);

                n = $urandom_range(0, 20);
                repeat (n)
                begin
                    if ($urandom_range(0, 15) == 0)
                        c = CH_CR;
                    else if ($urandom_range(0, 7) == 0)
                    begin
                        do c = 8'($urandom_range(0, 255));
                        while (c == CH_LF || c == CH_CR || c == CH_STAR);
                    end
                    else
                    begin
                        do c = 8'($urandom_range(32, 126)); while (c == CH_STAR);
                    end
                    line_buf.push_back(c);
                end

                sum  = line_sum();
                form = $urandom_range(0, 9);
                if (form != 0)
                    line_buf.push_back(CH_STAR);
                if (form == 2)
                    line_buf.push_back(hex_char(sum[3:0], 1'($urandom_range(0, 1))));
                else if (form >= 3)
                begin
                    // corrupt the checksum now and then
                    if (form == 3)
                        sum ^= 8'($urandom_range(1, 255));
                    line_buf.push_back(hex_char(sum[7:4], 1'($urandom_range(0, 1))));
                    line_buf.push_back(hex_char(sum[3:0], 1'($urandom_range(0, 1))));
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    n = $urandom_range(1, 4);
                    repeat (n)
                        line_buf.push_back(8'($urandom_range(8'h2C, 8'h66)));
                end
                if ($urandom_range(0, 1) == 1)
                    line_buf.push_back(CH_CR);
                line_buf.push_back(CH_LF);
            end
            send_line();
        end

        in_valid <= 1'b0;
        @(negedge clk);
        while (verdicts_owed != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/nsff_pkg.sv
rtl/nsff_line_state.sv
rtl/nmea_sentence_framer_filter.sv
rtl/nsff_checker.sv
tb/nsff_verdict_checker.sv
tb/tb_top.sv
